FILE: design/sliding_median_ternary_threshold_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding median ternary threshold block
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_TERNARY_THRESHOLD_ASSERT_SVH
`define SLIDING_MEDIAN_TERNARY_THRESHOLD_ASSERT_SVH
`ifndef SYNTHESIS
`define SMTT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SMTT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SMTT_ASSERT_IMP(label, ante, cons, msg)
`define SMTT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: design/smtt_pkg.sv
// ----------------------------------------------------------------------------
// smtt_pkg
// Constants, register codes and controller states of the median threshold.
// ----------------------------------------------------------------------------
package smtt_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_RADIUS = 7;
   localparam int MAX_OUT        = 64;
   localparam int OUT_CNT_W      = 7;

   localparam int PIX_W   = 8;
   localparam int OCOL_W  = 10;
   localparam int ROW_W   = 12;
   localparam int RAD_W   = 3;
   localparam int THR_W   = 8;
   localparam int FW_W    = 11;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [RAD_W-1:0] RST_RADIUS    = 3'd7;
   localparam logic [THR_W-1:0] RST_THRESHOLD = 8'd30;
   localparam logic [FW_W-1:0]  RST_WIDTH     = 11'd640;
   localparam logic [ROW_W-1:0] RST_HEIGHT    = 12'd480;

   localparam logic [PIX_W-1:0] CLASS_DARK   = 8'd0;
   localparam logic [PIX_W-1:0] CLASS_MID    = 8'd128;
   localparam logic [PIX_W-1:0] CLASS_BRIGHT = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RADIUS    = 2'd0,
      REG_THRESHOLD = 2'd1,
      REG_WIDTH     = 2'd2,
      REG_HEIGHT    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_INIT,
      S_SCAN,
      S_SCAN_END,
      S_CLASS,
      S_OUT
   } state_type;

endpackage

FILE: design/sliding_median_ternary_threshold.sv
// ----------------------------------------------------------------------------
// sliding_median_ternary_threshold
// Classifies each pixel against the median of its clipped square window.
//
//   channel | dir | handshake                  | payload
//   req     | in  | req_tvalid / req_tready    | req_tdata: pixel_in
//   rsp     | out | rsp_tvalid / rsp_tready    | rsp_tdata, rsp_tlast: run_last
//   csr     | in  | csr_valid / csr_ready      | csr_index, csr_data
//
// Each result is computed over its clipped window of N pixels (up to 225),
// after a check of its position (repeated at each row wrap), and is then
// handed out. The median is found one bit per pass over the window, and each
// pass reads the line store through its single read port, one pixel a cycle.
// Reset is synchronous and restores the register defaults; the line store is
// not cleared. A stalled result holds the block until it is taken.
// ----------------------------------------------------------------------------
`include "sliding_median_ternary_threshold_assert.svh"

module sliding_median_ternary_threshold #(
   parameter int MAX_WIDTH  = smtt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = smtt_pkg::DEF_MAX_RADIUS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] pixel_out, [17:8] out_col, [29:18] out_row
   output logic        rsp_tlast,   // run_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int RING  = 2 * MAX_RADIUS + 1;
   localparam int RW    = $clog2(RING);
   localparam int DEPTH = RING * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int EW    = (CW > smtt_pkg::FW_W) ? CW : smtt_pkg::FW_W;
   localparam int NW    = $clog2(RING * RING + 1);
   localparam int RWD   = smtt_pkg::ROW_W;
   localparam int PW    = smtt_pkg::PIX_W;

   smtt_pkg::state_type state_ff, state_in;

   logic [smtt_pkg::RAD_W-1:0] radius_ff;
   logic [smtt_pkg::THR_W-1:0] thr_ff;
   logic [smtt_pkg::FW_W-1:0]  width_ff;
   logic [RWD-1:0]             height_ff;

   logic [CW-1:0]  col_ff, col_in;
   logic [RWD-1:0] row_ff, row_in;
   logic [RW-1:0]  wring_ff, wring_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  ocol_ff, ocol_in;
   logic [RWD-1:0] orow_ff, orow_in;
   logic [RW-1:0]  oring_ff, oring_in;

   logic [RWD-1:0] i_ff, i_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [RW-1:0]  ri_ff, ri_in, ring0_ff, ring0_in;
   logic [CW-1:0]  j_ff, j_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [2:0]     bit_ff, bit_in;
   logic [PW-1:0]  pfx_ff, pfx_in;
   logic [NW-1:0]  cnt_ff, cnt_in, win_ff, win_in;
   logic           rdv_ff, rdv_in, ctrd_ff, ctrd_in;
   logic [PW-1:0]  val_ff, val_in;
   logic [AW-1:0]  rd_addr;
   logic [PW-1:0]  mem_q;

   logic [smtt_pkg::OUT_CNT_W-1:0] nres_ff, nres_in;
   logic           pend_ff, pend_in, last_ff, last_in;
   logic [PW-1:0]  rpix_ff, rpix_in;
   logic [CW-1:0]  rcol_ff, rcol_in;
   logic [RWD-1:0] rrow_ff, rrow_in;

   logic [PW-1:0]  line_mem [DEPTH];

   logic [smtt_pkg::RAD_W-1:0] rad;
   logic [EW-1:0]  w_ext;
   logic [CW-1:0]  w;
   logic [RWD-1:0] h;
   logic           accept, wr_en, rsp_fire;
   logic [AW-1:0]  wr_addr;
   logic [RWD:0]   nr;
   logic [CW:0]    nc;
   logic           ready_ok, col_wrap, row_end, go;
   logic [PW-1:0]  cand;
   logic [NW-1:0]  cnt_sum, win_sum;
   logic           hit;
   logic [PW:0]    lo_sum, hi_sum;
   logic [PW-1:0]  cls;

   // effective register values
   always_comb begin
      rad = (radius_ff > smtt_pkg::RAD_W'(MAX_RADIUS)) ?
            smtt_pkg::RAD_W'(MAX_RADIUS) : radius_ff;
      if (width_ff == '0) begin
         w_ext = EW'(1);
      end else if (EW'(width_ff) > EW'(MAX_WIDTH)) begin
         w_ext = EW'(MAX_WIDTH);
      end else begin
         w_ext = EW'(width_ff);
      end
      w = w_ext[CW-1:0];
      h = (height_ff == '0) ? RWD'(1) : height_ff;
   end

   // configuration
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= smtt_pkg::RST_RADIUS;
         thr_ff    <= smtt_pkg::RST_THRESHOLD;
         width_ff  <= smtt_pkg::RST_WIDTH;
         height_ff <= smtt_pkg::RST_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (smtt_pkg::reg_index_type'(csr_index))
            smtt_pkg::REG_RADIUS:    radius_ff <= csr_data[smtt_pkg::RAD_W-1:0];
            smtt_pkg::REG_THRESHOLD: thr_ff    <= csr_data[smtt_pkg::THR_W-1:0];
            smtt_pkg::REG_WIDTH:     width_ff  <= csr_data[smtt_pkg::FW_W-1:0];
            smtt_pkg::REG_HEIGHT:    height_ff <= csr_data[RWD-1:0];
            default: ;
         endcase
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign wr_en    = accept && !done_ff;
   assign wr_addr  = AW'(wring_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign rd_addr  = AW'(ri_ff) * AW'(MAX_WIDTH) + AW'(j_ff);

   // line store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= req_tdata;
      end
      mem_q <= line_mem[rd_addr];
   end

   // readiness of the next result position
   always_comb begin
      nr = {1'b0, orow_ff} + (RWD+1)'(rad);
      if (nr > {1'b0, h - RWD'(1)}) begin
         nr = {1'b0, h - RWD'(1)};
      end
      nc = {1'b0, ocol_ff} + (CW+1)'(rad);
      if (nc > {1'b0, w - CW'(1)}) begin
         nc = {1'b0, w - CW'(1)};
      end
      ready_ok = done_ff || (nr < {1'b0, row_ff}) ||
                 ((nr == {1'b0, row_ff}) && (nc < {1'b0, col_ff}));
      col_wrap = (ocol_ff >= w);
      row_end  = (orow_ff >= h);
      go       = !col_wrap && !row_end && ready_ok;
   end

   // median bit test and class
   always_comb begin
      cand    = pfx_ff | (PW'(1) << bit_ff);
      hit     = rdv_ff && (mem_q < cand);
      cnt_sum = cnt_ff + NW'(hit);
      win_sum = win_ff + NW'(rdv_ff);
      lo_sum  = {1'b0, val_ff} + {1'b0, thr_ff};
      hi_sum  = {1'b0, pfx_ff} + {1'b0, thr_ff};
      if (lo_sum < {1'b0, pfx_ff}) begin
         cls = smtt_pkg::CLASS_DARK;
      end else if ({1'b0, val_ff} > hi_sum) begin
         cls = smtt_pkg::CLASS_BRIGHT;
      end else begin
         cls = smtt_pkg::CLASS_MID;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smtt_pkg::S_IDLE: begin
            if (accept) state_in = smtt_pkg::S_CHECK;
         end
         smtt_pkg::S_CHECK: begin
            if (col_wrap) begin
               state_in = smtt_pkg::S_CHECK;
            end else if (go) begin
               state_in = pend_ff ? smtt_pkg::S_OUT : smtt_pkg::S_INIT;
            end else begin
               state_in = pend_ff ? smtt_pkg::S_OUT : smtt_pkg::S_IDLE;
            end
         end
         smtt_pkg::S_INIT: state_in = smtt_pkg::S_SCAN;
         smtt_pkg::S_SCAN: begin
            if (j_ff == c1_ff && i_ff == r1_ff) state_in = smtt_pkg::S_SCAN_END;
         end
         smtt_pkg::S_SCAN_END: begin
            state_in = (bit_ff == 3'd0) ? smtt_pkg::S_CLASS : smtt_pkg::S_SCAN;
         end
         smtt_pkg::S_CLASS: begin
            state_in = (nres_ff == smtt_pkg::OUT_CNT_W'(smtt_pkg::MAX_OUT - 1)) ?
                       smtt_pkg::S_OUT : smtt_pkg::S_CHECK;
         end
         smtt_pkg::S_OUT: begin
            if (rsp_fire) state_in = last_ff ? smtt_pkg::S_IDLE : smtt_pkg::S_INIT;
         end
         default: state_in = smtt_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == smtt_pkg::S_IDLE);
      rsp_tvalid = (state_ff == smtt_pkg::S_OUT);
      rsp_tdata  = {2'b00, rrow_ff, smtt_pkg::OCOL_W'(rcol_ff), rpix_ff};
      rsp_tlast  = last_ff;
   end

   // datapath
   always_comb begin
      col_in = col_ff;     row_in = row_ff;     wring_in = wring_ff;
      done_in = done_ff;   ocol_in = ocol_ff;   orow_in = orow_ff;
      oring_in = oring_ff; i_in = i_ff;         ri_in = ri_ff;
      j_in = j_ff;         r0_in = r0_ff;       r1_in = r1_ff;
      c0_in = c0_ff;       c1_in = c1_ff;       ring0_in = ring0_ff;
      bit_in = bit_ff;     pfx_in = pfx_ff;     val_in = val_ff;
      nres_in = nres_ff;   pend_in = pend_ff;   last_in = last_ff;
      rpix_in = rpix_ff;   rcol_in = rcol_ff;   rrow_in = rrow_ff;
      rdv_in  = 1'b0;      ctrd_in = 1'b0;
      cnt_in  = rdv_ff ? cnt_sum : cnt_ff;
      win_in  = rdv_ff ? win_sum : win_ff;
      if (ctrd_ff) val_in = mem_q;

      case (state_ff)
         smtt_pkg::S_IDLE: begin
            if (accept) begin
               nres_in = '0;
               if (!done_ff) begin
                  if ((CW+1)'(col_ff) + (CW+1)'(1) >= {1'b0, w}) begin
                     col_in = '0;
                     row_in = row_ff + RWD'(1);
                     wring_in = (wring_ff == RW'(RING - 1)) ? '0 : wring_ff + RW'(1);
                     if ({1'b0, row_ff} + (RWD+1)'(1) >= {1'b0, h}) done_in = 1'b1;
                  end else begin
                     col_in = col_ff + CW'(1);
                  end
               end
            end
         end
         smtt_pkg::S_CHECK: begin
            if (col_wrap) begin
               ocol_in  = '0;
               orow_in  = orow_ff + RWD'(1);
               oring_in = (oring_ff == RW'(RING - 1)) ? '0 : oring_ff + RW'(1);
            end else if (row_end) begin
               if (done_ff) begin
                  row_in = '0;  col_in = '0;  wring_in = '0;
                  orow_in = '0; ocol_in = '0; oring_in = '0;
                  done_in = 1'b0;
               end
               last_in = 1'b1;
            end else begin
               last_in = !ready_ok;
            end
         end
         smtt_pkg::S_INIT: begin
            r0_in = (orow_ff > RWD'(rad)) ? orow_ff - RWD'(rad) : '0;
            c0_in = (ocol_ff > CW'(rad)) ? ocol_ff - CW'(rad) : '0;
            r1_in = nr[RWD-1:0];
            c1_in = nc[CW-1:0];
            if (oring_ff >= RW'(orow_ff - r0_in)) begin
               ring0_in = oring_ff - RW'(orow_ff - r0_in);
            end else begin
               ring0_in = RW'((RW+1)'(oring_ff) + (RW+1)'(RING) - (RW+1)'(orow_ff - r0_in));
            end
            i_in = r0_in;  ri_in = ring0_in;  j_in = c0_in;
            bit_in = 3'd7; pfx_in = '0; cnt_in = '0; win_in = '0;
         end
         smtt_pkg::S_SCAN: begin
            rdv_in  = 1'b1;
            ctrd_in = (i_ff == orow_ff) && (j_ff == ocol_ff);
            if (j_ff == c1_ff) begin
               j_in = c0_ff;
               if (i_ff != r1_ff) begin
                  i_in  = i_ff + RWD'(1);
                  ri_in = (ri_ff == RW'(RING - 1)) ? '0 : ri_ff + RW'(1);
               end
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         smtt_pkg::S_SCAN_END: begin
            if (!(cnt_sum > (win_sum >> 1))) pfx_in = cand;
            cnt_in = '0;  win_in = '0;
            bit_in = bit_ff - 3'd1;
            i_in = r0_ff; ri_in = ring0_ff; j_in = c0_ff;
         end
         smtt_pkg::S_CLASS: begin
            rpix_in = cls;
            rcol_in = ocol_ff;
            rrow_in = orow_ff;
            ocol_in = ocol_ff + CW'(1);
            nres_in = nres_ff + smtt_pkg::OUT_CNT_W'(1);
            pend_in = 1'b1;
            last_in = (nres_ff == smtt_pkg::OUT_CNT_W'(smtt_pkg::MAX_OUT - 1));
         end
         smtt_pkg::S_OUT: begin
            if (rsp_fire) pend_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smtt_pkg::S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         wring_ff <= '0;
         done_ff  <= 1'b0;
         ocol_ff  <= '0;
         orow_ff  <= '0;
         oring_ff <= '0;
         nres_ff  <= '0;
         pend_ff  <= 1'b0;
         last_ff  <= 1'b0;
         rdv_ff   <= 1'b0;
         ctrd_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         wring_ff <= wring_in;
         done_ff  <= done_in;
         ocol_ff  <= ocol_in;
         orow_ff  <= orow_in;
         oring_ff <= oring_in;
         nres_ff  <= nres_in;
         pend_ff  <= pend_in;
         last_ff  <= last_in;
         rdv_ff   <= rdv_in;
         ctrd_ff  <= ctrd_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      ri_ff    <= ri_in;
      j_ff     <= j_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      ring0_ff <= ring0_in;
      bit_ff   <= bit_in;
      pfx_ff   <= pfx_in;
      cnt_ff   <= cnt_in;
      win_ff   <= win_in;
      val_ff   <= val_in;
      rpix_ff  <= rpix_in;
      rcol_ff  <= rcol_in;
      rrow_ff  <= rrow_in;
   end

   `SMTT_ASSERT_IMP(a_no_overlap, rsp_tvalid, !req_tready, "input taken while result pending")
   `SMTT_ASSERT_NXT(a_last_idle, rsp_fire && rsp_tlast, req_tready, "no idle after last result")
   `SMTT_ASSERT_IMP(a_out_limit, 1'b1, nres_ff <= smtt_pkg::OUT_CNT_W'(smtt_pkg::MAX_OUT),
                    "too many results for one item")

endmodule
